// ===== hdl/c2r_pkg.sv =====
// shared types, constants and helper functions of the component to rgba8 converter
package c2r_pkg;

    localparam int COEF_FRAC_BITS_DEF = 16;

    // widths of the sample scaling datapath
    localparam int SAMPLE_W = 32;
    localparam int FMT_W    = 6;
    localparam int MAXV_W   = 30;
    localparam int V_W      = 33;
    localparam int N_W      = 42;
    localparam int REM_W    = 38;

    // pipeline depth: six scaling stages and two color stages
    localparam int SCALE_STAGES = 6;
    localparam int COLOR_STAGES = 2;
    localparam int PIPE_STAGES  = SCALE_STAGES + COLOR_STAGES;

    typedef enum logic [1:0] {
        CM_PASS = 2'd0,
        CM_YCC  = 2'd1,
        CM_CMYK = 2'd2
    } t_color_mode;

    typedef enum logic [1:0] {
        FU_ABSENT = 2'd0,
        FU_ALPHA  = 2'd1,
        FU_OPAQUE = 2'd2
    } t_fourth_use;

    typedef enum logic [2:0] {
        REG_COLOR_MODE = 3'd0,
        REG_GRAY_BCAST = 3'd1,
        REG_FOURTH_USE = 3'd2,
        REG_PLANE0_FMT = 3'd3,
        REG_PLANE1_FMT = 3'd4,
        REG_PLANE2_FMT = 3'd5,
        REG_PLANE3_FMT = 3'd6
    } t_cfg_reg;

    localparam logic [FMT_W-1:0] FMT_RESET = 6'd8;

    // effective precision: 0 means 8, 31 means 30
    function automatic logic [4:0] fmt_prec(input logic [FMT_W-1:0] fmt);
        logic [4:0] p;
        p = fmt[4:0];
        if (p == 5'd0) begin
            p = 5'd8;
        end else if (p == 5'd31) begin
            p = 5'd30;
        end
        return p;
    endfunction

    function automatic logic [MAXV_W-1:0] fmt_maxv(input logic [FMT_W-1:0] fmt);
        logic [MAXV_W:0] t;
        t = ({{MAXV_W{1'b0}}, 1'b1} << fmt_prec(fmt)) - {{MAXV_W{1'b0}}, 1'b1};
        return t[MAXV_W-1:0];
    endfunction

    // two restoring division steps for quotient bits hi and hi-1
    function automatic logic [REM_W+1:0] div_pair(
        input logic [REM_W-1:0]  rem,
        input logic [MAXV_W-1:0] maxv,
        input int                hi
    );
        logic [REM_W-1:0] d;
        logic [REM_W-1:0] r;
        logic [1:0]       q;
        r = rem;
        d = REM_W'(maxv) << hi;
        q[1] = (r >= d);
        if (q[1]) begin
            r = r - d;
        end
        d = REM_W'(maxv) << (hi - 1);
        q[0] = (r >= d);
        if (q[0]) begin
            r = r - d;
        end
        return {q, r};
    endfunction

endpackage

// ===== hdl/c2r_scale.sv =====
// six-stage pipeline that scales one raw sample to 8 bits by its plane format
module c2r_scale (
    input  logic                                i_clk,
    input  logic [c2r_pkg::SCALE_STAGES-1:0]    i_en,
    input  logic [c2r_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic [c2r_pkg::FMT_W-1:0]           i_fmt,
    output logic [7:0]                          o_comp
);

    localparam int VW = c2r_pkg::V_W;
    localparam int NW = c2r_pkg::N_W;
    localparam int RW = c2r_pkg::REM_W;
    localparam int DIV_STAGES = 4;

    logic [c2r_pkg::MAXV_W-1:0] maxv;
    logic [4:0]                 prec;

    logic signed [VW-1:0] n_v;
    logic signed [VW-1:0] r_v;
    logic signed [NW-1:0] n_n;
    logic signed [NW-1:0] r_n;

    logic [RW-1:0] n_rem [DIV_STAGES];
    logic [RW-1:0] r_rem [DIV_STAGES];
    logic [7:0]    n_q   [DIV_STAGES];
    logic [7:0]    r_q   [DIV_STAGES];
    logic          n_neg [DIV_STAGES];
    logic          r_neg [DIV_STAGES];
    logic          n_sat [DIV_STAGES];
    logic          r_sat [DIV_STAGES];

    // format must only be rewritten while the pipeline is empty; this block does not enforce it
    assign prec = c2r_pkg::fmt_prec(i_fmt);
    assign maxv = c2r_pkg::fmt_maxv(i_fmt);

    // signed planes are offset by half range
    always_comb begin
        n_v = VW'($signed(i_sample));
        if (i_fmt[5]) begin
            n_v = n_v + (VW'(1) << (prec - 5'd1));
        end
    end

    // v*255 plus half the divisor for rounding
    assign n_n = (NW'(r_v) <<< 8) - NW'(r_v) + NW'(maxv >> 1);

    always_comb begin
        logic [RW+1:0] pr;
        pr = c2r_pkg::div_pair(r_n[RW-1:0], maxv, 7);
        n_neg[0] = r_n[NW-1];
        n_sat[0] = !r_n[NW-1] && (r_n[NW-2:0] >= (NW-1)'({maxv, 8'd0}));
        n_rem[0] = pr[RW-1:0];
        n_q[0]   = {6'd0, pr[RW+1:RW]};
        for (int g = 1; g < DIV_STAGES; g++) begin
            pr = c2r_pkg::div_pair(r_rem[g-1], maxv, 7 - 2 * g);
            n_neg[g] = r_neg[g-1];
            n_sat[g] = r_sat[g-1];
            n_rem[g] = pr[RW-1:0];
            n_q[g]   = {r_q[g-1][5:0], pr[RW+1:RW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_v <= n_v;
        end
        if (i_en[1]) begin
            r_n <= n_n;
        end
        for (int g = 0; g < DIV_STAGES; g++) begin
            if (i_en[g + 2]) begin
                r_rem[g] <= n_rem[g];
                r_q[g]   <= n_q[g];
                r_neg[g] <= n_neg[g];
                r_sat[g] <= n_sat[g];
            end
        end
    end

    assign o_comp = r_neg[DIV_STAGES-1] ? 8'd0 :
                    r_sat[DIV_STAGES-1] ? 8'd255 : r_q[DIV_STAGES-1];

endmodule

// ===== hdl/c2r_color.sv =====
// two-stage color conversion: products first, then sums, rounding and output bytes
module c2r_color #(
    parameter int COEF_FRAC_BITS = c2r_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic [c2r_pkg::COLOR_STAGES-1:0]    i_en,
    input  c2r_pkg::t_color_mode                i_color_mode,
    input  logic                                i_gray,
    input  c2r_pkg::t_fourth_use                i_fourth_use,
    input  logic [7:0]                          i_c0,
    input  logic [7:0]                          i_c1,
    input  logic [7:0]                          i_c2,
    input  logic [7:0]                          i_c3,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue,
    output logic [7:0]                          o_alpha
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int KW = F + 2;
    localparam int PW = KW + 9;
    localparam int AW = F + 11;

    localparam longint unsigned KU_CR_R = ((64'd1402000 << F) + 64'd500000) / 64'd1000000;
    localparam longint unsigned KU_CB_G = ((64'd344136 << F) + 64'd500000) / 64'd1000000;
    localparam longint unsigned KU_CR_G = ((64'd714136 << F) + 64'd500000) / 64'd1000000;
    localparam longint unsigned KU_CB_B = ((64'd1772000 << F) + 64'd500000) / 64'd1000000;

    localparam logic signed [KW-1:0] K_CR_R = KW'(KU_CR_R);
    localparam logic signed [KW-1:0] K_CB_G = KW'(KU_CB_G);
    localparam logic signed [KW-1:0] K_CR_G = KW'(KU_CR_G);
    localparam logic signed [KW-1:0] K_CB_B = KW'(KU_CB_B);

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (F - 1);

    function automatic logic [7:0] fix_to_u8(input logic signed [AW-1:0] acc);
        logic [7:0] r;
        if (acc[AW-1]) begin
            r = 8'd0;
        end else if (|acc[AW-2:F+8]) begin
            r = 8'd255;
        end else begin
            r = acc[F+7:F];
        end
        return r;
    endfunction

    function automatic logic [7:0] div255(input logic [15:0] prod);
        logic [16:0] t;
        logic [16:0] u;
        t = {1'b0, prod} + 17'd128;
        u = t + (t >> 8);
        return u[15:8];
    endfunction

    logic [7:0]        c1e;
    logic [7:0]        c2e;
    logic [7:0]        c3e;
    logic [7:0]        kb;
    logic signed [8:0] cb;
    logic signed [8:0] cr;

    logic [7:0]           r_c0;
    logic [7:0]           r_c1;
    logic [7:0]           r_c2;
    logic [7:0]           r_a;
    logic signed [PW-1:0] r_p_rr;
    logic signed [PW-1:0] r_p_gb;
    logic signed [PW-1:0] r_p_gr;
    logic signed [PW-1:0] r_p_bb;
    logic [15:0]          r_m0;
    logic [15:0]          r_m1;
    logic [15:0]          r_m2;

    logic signed [AW-1:0] y_ext;
    logic signed [AW-1:0] acc_r;
    logic signed [AW-1:0] acc_g;
    logic signed [AW-1:0] acc_b;
    logic [7:0]           n_red;
    logic [7:0]           n_green;
    logic [7:0]           n_blue;

    // gray broadcast reuses component zero
    assign c1e = i_gray ? i_c0 : i_c1;
    assign c2e = i_gray ? i_c0 : i_c2;
    assign c3e = (i_fourth_use == c2r_pkg::FU_ABSENT) ? 8'd255 : i_c3;
    assign kb  = 8'd255 - c3e;
    assign cb  = $signed({1'b0, c1e}) - 9'sd128;
    assign cr  = $signed({1'b0, c2e}) - 9'sd128;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_c0   <= i_c0;
            r_c1   <= c1e;
            r_c2   <= c2e;
            r_a    <= (i_fourth_use == c2r_pkg::FU_ALPHA) ? c3e : 8'd255;
            r_p_rr <= PW'(K_CR_R * cr);
            r_p_gb <= PW'(K_CB_G * cb);
            r_p_gr <= PW'(K_CR_G * cr);
            r_p_bb <= PW'(K_CB_B * cb);
            r_m0   <= (8'd255 - i_c0) * kb;
            r_m1   <= (8'd255 - c1e) * kb;
            r_m2   <= (8'd255 - c2e) * kb;
        end
    end

    assign y_ext = $signed({{(AW-8){1'b0}}, r_c0}) <<< F;
    assign acc_r = y_ext + AW'(r_p_rr) + HALF;
    assign acc_g = y_ext - AW'(r_p_gb) - AW'(r_p_gr) + HALF;
    assign acc_b = y_ext + AW'(r_p_bb) + HALF;

    always_comb begin
        case (i_color_mode)
            c2r_pkg::CM_YCC: begin
                n_red   = fix_to_u8(acc_r);
                n_green = fix_to_u8(acc_g);
                n_blue  = fix_to_u8(acc_b);
            end
            c2r_pkg::CM_CMYK: begin
                n_red   = div255(r_m0);
                n_green = div255(r_m1);
                n_blue  = div255(r_m2);
            end
            default: begin
                n_red   = r_c0;
                n_green = r_c1;
                n_blue  = r_c2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_red   <= n_red;
            o_green <= n_green;
            o_blue  <= n_blue;
            o_alpha <= r_a;
        end
    end

endmodule

// ===== hdl/component_to_rgba8_converter.sv =====
// Component to RGBA8 converter, top level.
// Input channel: i_valid / o_stall with four raw 32-bit samples per item;
// an item is taken at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with one RGBA byte quadruple per item.
// On the way from acceptance to o_valid, six stages scale each
// sample (offset, multiply by 255, four stages of two restoring division
// steps against 2^p-1), then one stage of color products and one stage of
// sums, rounding and output registers.
// Throughput is one item per clock; every stage holds a valid bit and
// loads whenever it is empty or its successor moves, so a stalled output
// keeps its item while empty stages upstream still fill.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data and
// must only be written while no item is in flight (the block does not
// enforce this); index 7 is ignored. Synchronous active-low reset empties
// the pipeline and restores the registers: pass-through, no broadcast,
// fourth absent, all planes 8-bit unsigned.
module component_to_rgba8_converter #(
    parameter int COEF_FRAC_BITS = c2r_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_sample0,
    input  logic [31:0] i_sample1,
    input  logic [31:0] i_sample2,
    input  logic [31:0] i_sample3,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);

    localparam int NS = c2r_pkg::PIPE_STAGES;
    localparam int SS = c2r_pkg::SCALE_STAGES;

    c2r_pkg::t_color_mode r_color_mode;
    logic                 r_gray;
    c2r_pkg::t_fourth_use r_fourth_use;
    logic [5:0]           r_fmt [4];

    logic [NS:1] r_vld;
    logic [NS:1] free;
    logic [7:0]  comp [4];
    logic [31:0] samples [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= c2r_pkg::CM_PASS;
            r_gray       <= 1'b0;
            r_fourth_use <= c2r_pkg::FU_ABSENT;
            r_fmt[0]     <= c2r_pkg::FMT_RESET;
            r_fmt[1]     <= c2r_pkg::FMT_RESET;
            r_fmt[2]     <= c2r_pkg::FMT_RESET;
            r_fmt[3]     <= c2r_pkg::FMT_RESET;
        end else if (i_cfg_we) begin
            case (c2r_pkg::t_cfg_reg'(i_cfg_idx))
                c2r_pkg::REG_COLOR_MODE: r_color_mode <= c2r_pkg::t_color_mode'(i_cfg_data[1:0]);
                c2r_pkg::REG_GRAY_BCAST: r_gray       <= i_cfg_data[0];
                c2r_pkg::REG_FOURTH_USE: r_fourth_use <= c2r_pkg::t_fourth_use'(i_cfg_data[1:0]);
                c2r_pkg::REG_PLANE0_FMT: r_fmt[0]     <= i_cfg_data;
                c2r_pkg::REG_PLANE1_FMT: r_fmt[1]     <= i_cfg_data;
                c2r_pkg::REG_PLANE2_FMT: r_fmt[2]     <= i_cfg_data;
                c2r_pkg::REG_PLANE3_FMT: r_fmt[3]     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its successor moves on
    always_comb begin
        free[NS] = !r_vld[NS] || !i_stall;
        for (int k = NS - 1; k >= 1; k--) begin
            free[k] = !r_vld[k] || free[k+1];
        end
    end

    assign o_stall = !free[1];
    assign o_valid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (free[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (free[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign samples[0] = i_sample0;
    assign samples[1] = i_sample1;
    assign samples[2] = i_sample2;
    assign samples[3] = i_sample3;

    for (genvar c = 0; c < 4; c++) begin : g_scale
        c2r_scale u_scale (
            .i_clk    (i_clk),
            .i_en     (free[SS:1]),
            .i_sample (samples[c]),
            .i_fmt    (r_fmt[c]),
            .o_comp   (comp[c])
        );
    end

    c2r_color #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_color (
        .i_clk        (i_clk),
        .i_en         (free[NS:SS+1]),
        .i_color_mode (r_color_mode),
        .i_gray       (r_gray),
        .i_fourth_use (r_fourth_use),
        .i_c0         (comp[0]),
        .i_c1         (comp[1]),
        .i_c2         (comp[2]),
        .i_c3         (comp[3]),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha)
    );

endmodule

// ===== tb/tb_component_to_rgba8_converter.sv =====
// self-checking testbench of the component to rgba8 converter with its own pixel predictor
`timescale 1ns / 1ps

module tb_component_to_rgba8_converter;

    localparam int FRAC_BITS = c2r_pkg::COEF_FRAC_BITS_DEF;

    // register values that have no name in the package
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [1:0] FOURTH_UNUSED = 2'd3;

    class rgba_scoreboard;
        typedef logic [3:0][7:0] rgba_t;   // byte 0 red .. byte 3 alpha

        rgba_t      expected_pixels[$];
        int         failures;
        logic [1:0] color_mode;
        logic       gray_bcast;
        logic [1:0] fourth_use;
        logic [5:0] plane_fmt[4];
        longint     k_cr_r, k_cb_g, k_cr_g, k_cb_b;

        function new();
            failures   = 0;
            color_mode = c2r_pkg::CM_PASS;
            gray_bcast = 1'b0;
            fourth_use = c2r_pkg::FU_ABSENT;
            foreach (plane_fmt[i]) plane_fmt[i] = c2r_pkg::FMT_RESET;
            k_cr_r = to_fixed(1402000);
            k_cb_g = to_fixed(344136);
            k_cr_g = to_fixed(714136);
            k_cb_b = to_fixed(1772000);
        endfunction

        // coefficient given in millionths, rounded to FRAC_BITS fraction bits
        function longint to_fixed(longint micro);
            return ((micro << FRAC_BITS) + 500000) / 1000000;
        endfunction

        function void set_reg(c2r_pkg::t_cfg_reg idx, logic [5:0] data);
            case (idx)
                c2r_pkg::REG_COLOR_MODE: color_mode = data[1:0];
                c2r_pkg::REG_GRAY_BCAST: gray_bcast = data[0];
                c2r_pkg::REG_FOURTH_USE: fourth_use = data[1:0];
                c2r_pkg::REG_PLANE0_FMT: plane_fmt[0] = data;
                c2r_pkg::REG_PLANE1_FMT: plane_fmt[1] = data;
                c2r_pkg::REG_PLANE2_FMT: plane_fmt[2] = data;
                c2r_pkg::REG_PLANE3_FMT: plane_fmt[3] = data;
                default: ;
            endcase
        endfunction

        function int scale_to_byte(logic [31:0] raw, logic [5:0] fmt);
            int     prec;
            longint v, maxv, n, q;
            prec = fmt[4:0];
            if (prec == 0) begin
                prec = 8;
            end else if (prec == 31) begin
                prec = 30;
            end
            maxv = (longint'(1) << prec) - 1;
            v = longint'($signed(raw));
            if (fmt[5]) begin
                v = v + (longint'(1) << (prec - 1));
            end
            n = v * 255 + maxv / 2;
            if (n < 0) return 0;
            q = n / maxv;
            return (q > 255) ? 255 : int'(q);
        endfunction

        function int fix_to_byte(longint acc);
            if (acc < 0) return 0;
            acc = acc >>> FRAC_BITS;
            return (acc > 255) ? 255 : int'(acc);
        endfunction

        function rgba_t convert_pixel(logic [31:0] s0, s1, s2, s3);
            int     c0, c1, c2, c3, k;
            longint y, cb, cr, half;
            rgba_t  px;
            c0 = scale_to_byte(s0, plane_fmt[0]);
            if (gray_bcast) begin
                c1 = c0;
                c2 = c0;
            end else begin
                c1 = scale_to_byte(s1, plane_fmt[1]);
                c2 = scale_to_byte(s2, plane_fmt[2]);
            end
            c3 = (fourth_use == c2r_pkg::FU_ABSENT) ? 255 : scale_to_byte(s3, plane_fmt[3]);
            if (color_mode == c2r_pkg::CM_YCC) begin
                y    = longint'(c0) << FRAC_BITS;
                cb   = c1 - 128;
                cr   = c2 - 128;
                half = longint'(1) << (FRAC_BITS - 1);
                px[0] = 8'(fix_to_byte(y + k_cr_r * cr + half));
                px[1] = 8'(fix_to_byte(y - k_cb_g * cb - k_cr_g * cr + half));
                px[2] = 8'(fix_to_byte(y + k_cb_b * cb + half));
            end else if (color_mode == c2r_pkg::CM_CMYK) begin
                k = 255 - c3;
                px[0] = 8'(((255 - c0) * k + 127) / 255);
                px[1] = 8'(((255 - c1) * k + 127) / 255);
                px[2] = 8'(((255 - c2) * k + 127) / 255);
            end else begin
                px[0] = 8'(c0);
                px[1] = 8'(c1);
                px[2] = 8'(c2);
            end
            px[3] = (fourth_use == c2r_pkg::FU_ALPHA) ? 8'(c3) : 8'd255;
            return px;
        endfunction

        function void note_pixel_in(logic [31:0] s0, s1, s2, s3);
            expected_pixels.push_back(convert_pixel(s0, s1, s2, s3));
        endfunction

        function void check_pixel_out(logic [7:0] r, g, b, a);
            string channel[4] = '{"red", "green", "blue", "alpha"};
            rgba_t got;
            rgba_t want;
            got = {a, b, g, r};
            if (expected_pixels.size() == 0) begin
                $error("pixel %0d %0d %0d %0d with none expected", r, g, b, a);
                failures++;
                return;
            end
            want = expected_pixels.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (got[i] !== want[i]) begin
                    $error("%s: expected %0d, got %0d", channel[i], want[i], got[i]);
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_sample0;
    logic [31:0] i_sample1;
    logic [31:0] i_sample2;
    logic [31:0] i_sample3;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [5:0]  i_cfg_data;

    rgba_scoreboard rgba_sb = new();
    bit             back_to_back = 1'b0;

    component_to_rgba8_converter #(
        .COEF_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_sample0 (i_sample0),
        .i_sample1 (i_sample1),
        .i_sample2 (i_sample2),
        .i_sample3 (i_sample3),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue),
        .o_alpha   (o_alpha),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    // leaves the write enable high; apply_settings lowers it after the last write
    task automatic write_reg(input c2r_pkg::t_cfg_reg idx, input logic [5:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        rgba_sb.set_reg(idx, data);
    endtask

    // unused upper data bits of the narrow registers are filled at random
    task automatic apply_settings(input logic [1:0] mode, input logic gb,
                                  input logic [1:0] fu,
                                  input logic [5:0] f0, f1, f2, f3);
        write_reg(c2r_pkg::REG_COLOR_MODE, {4'($urandom), mode});
        write_reg(c2r_pkg::REG_GRAY_BCAST, {5'($urandom), gb});
        write_reg(c2r_pkg::REG_FOURTH_USE, {4'($urandom), fu});
        write_reg(c2r_pkg::REG_PLANE0_FMT, f0);
        write_reg(c2r_pkg::REG_PLANE1_FMT, f1);
        write_reg(c2r_pkg::REG_PLANE2_FMT, f2);
        write_reg(c2r_pkg::REG_PLANE3_FMT, f3);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [31:0] s0, s1, s2, s3);
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_sample0 <= s0;
        i_sample1 <= s1;
        i_sample2 <= s2;
        i_sample3 <= s3;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        rgba_sb.note_pixel_in(s0, s1, s2, s3);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (rgba_sb.pending() != 0) @(posedge i_clk);
    endtask

    // mostly in-range samples, some boundaries and some raw 32-bit values
    function automatic logic [31:0] draw_sample(input logic [5:0] fmt);
        int unsigned prec;
        logic [31:0] s;
        prec = fmt[4:0];
        if (prec == 0) begin
            prec = 8;
        end else if (prec == 31) begin
            prec = 30;
        end
        case ($urandom_range(0, 15))
            0: s = $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: s = 32'h8000_0000;
                    1: s = 32'h7fff_ffff;
                    2: s = 32'h0000_0000;
                    default: s = 32'hffff_ffff;
                endcase
            end
            2: begin
                s = (32'd1 << prec) - 32'($urandom_range(0, 1));
                if (fmt[5]) s = s - (32'd1 << (prec - 1));
            end
            default: begin
                s = $urandom & ((32'd1 << prec) - 32'd1);
                if (fmt[5]) s = s - (32'd1 << (prec - 1));
            end
        endcase
        return s;
    endfunction

    function automatic logic [5:0] draw_format();
        logic [5:0] f;
        f = 6'($urandom);
        if ($urandom_range(0, 1) == 0) f[4:0] = 5'd8;
        return f;
    endfunction

    // output side: random stall before each item unless back_to_back is set
    initial begin
        int unsigned hold;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = back_to_back ? 0 : $urandom_range(0, 12);
            repeat (hold) begin
                i_stall <= 1'b1;
                @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            rgba_sb.check_pixel_out(o_red, o_green, o_blue, o_alpha);
        end
    end

    initial begin
        logic [1:0] mode;
        logic       gb;
        logic [1:0] fu;
        logic [5:0] fmt[4];

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_sample0  <= '0;
        i_sample1  <= '0;
        i_sample2  <= '0;
        i_sample3  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= c2r_pkg::REG_COLOR_MODE;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settings right after reset
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 255, 255, 255);
        send_pixel(-1, 256, 32'h7fff_ffff, 32'h8000_0000);
        drain();

        // ycbcr with clamping at both ends
        apply_settings(c2r_pkg::CM_YCC, 1'b0, c2r_pkg::FU_ALPHA,
                       6'd8, 6'd8, 6'd8, 6'd8);
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 255, 255, 255);
        send_pixel(128, 128, 128, 128);
        send_pixel(255, 0, 255, 0);
        send_pixel(0, 255, 0, 255);
        drain();

        // cmyk without a fourth component gives black
        apply_settings(c2r_pkg::CM_CMYK, 1'b0, c2r_pkg::FU_ABSENT,
                       6'd8, 6'd8, 6'd8, 6'd8);
        send_pixel(10, 20, 30, 40);
        drain();

        apply_settings(c2r_pkg::CM_CMYK, 1'b0, c2r_pkg::FU_ALPHA,
                       6'd8, 6'd8, 6'd8, 6'd8);
        send_pixel(0, 128, 255, 0);
        send_pixel(255, 0, 0, 255);
        send_pixel(0, 0, 0, 128);
        drain();

        // unused mode, gray broadcast, one-bit signed and clipped precisions
        apply_settings(MODE_UNUSED, 1'b1, c2r_pkg::FU_ALPHA, 6'h21, 6'h1f, 6'h00, 6'h3f);
        send_pixel(-1, 32'h1234_5678, 32'hdead_beef, -(1 << 29));
        send_pixel(0, 0, 0, 32'h3fff_ffff);
        send_pixel(32'h8000_0000, -1, -1, 32'h7fff_ffff);
        drain();

        // unused fourth setting: present but not alpha
        apply_settings(c2r_pkg::CM_CMYK, 1'b0, FOURTH_UNUSED, 6'h3f, 6'h1f, 6'h20, 6'h01);
        send_pixel(32'h8000_0000, 32'hffff_ffff, 32'h8000_0000, 1);
        send_pixel(32'h7fff_ffff, 32'h3fff_ffff, 32'h7fff_ffff, 0);
        send_pixel(32'hc000_0000, 32'h4000_0000, 0, 32'hffff_ffff);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            mode = 2'(ph);
            gb   = ($urandom_range(0, 3) == 0);
            fu   = 2'($urandom_range(0, 3));
            foreach (fmt[j]) fmt[j] = draw_format();
            back_to_back = (ph % 3 == 2);
            apply_settings(mode, gb, fu, fmt[0], fmt[1], fmt[2], fmt[3]);
            repeat (90) begin
                send_pixel(draw_sample(fmt[0]), draw_sample(fmt[1]),
                           draw_sample(fmt[2]), draw_sample(fmt[3]));
            end
            drain();
        end

        // catch any stray item after the last expected one
        repeat (24) @(posedge i_clk);
        if (rgba_sb.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
